// File: design/leg_forward_kinematics_macros.svh
// Assertion macros for the leg forward kinematics block.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef LEG_FORWARD_KINEMATICS_MACROS_SVH
`define LEG_FORWARD_KINEMATICS_MACROS_SVH

// Condition implies property in the same cycle.
`define LFK_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition implies property in the next cycle.
`define LFK_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: design/lfk_pkg.sv
// Shared types, constants and tables of the leg forward kinematics block.
// Used by the CORDIC unit, the serial multiplier and the top level.
package lfk_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ANGLE_WIDTH_DEF       = 16;
    localparam int ATAN_ENTRIES          = 24;
    localparam int ATAN_IDX_W            = $clog2(ATAN_ENTRIES);
    localparam int ANG_W                 = 16;
    localparam int LEN_W                 = 16;
    localparam int TRIG_W                = 18;
    localparam int POS_W                 = 19;
    localparam int MUL_A_W               = 36;
    localparam int MUL_CNT_W             = $clog2(TRIG_W);
    localparam int ACC_W                 = 56;
    localparam int XY_W                  = 33;
    localparam longint PI_Q30            = 64'sd3373259426;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic MODE_EXACT = 1'b0;
    localparam logic MODE_FAST  = 1'b1;

    typedef enum logic [1:0] {
        REG_LEG_IS_RIGHT,
        REG_SHOULDER_LEN,
        REG_UPPER_LEN,
        REG_LOWER_LEN
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COR_START,
        ST_COR_WAIT,
        ST_MAC_START,
        ST_MAC_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_REDUCE,
        COR_ROTATE,
        COR_FINISH
    } t_cor_state;

    typedef enum logic [3:0] {
        OP_F0S, OP_F0C, OP_F1S, OP_F1C, OP_F2S, OP_F2C,
        OP_FX1, OP_FX2, OP_FY1, OP_FY2,
        OP_PX1, OP_PX2, OP_PY1, OP_PZ1, OP_PZ2
    } t_op;

    typedef enum logic [3:0] {
        A_D0, A_D1, A_D2, A_L0S, A_L1, A_L2, A_FY, A_L0S_LEFT, A_L0S_RIGHT
    } t_asel;

    typedef enum logic [2:0] {
        I_ZERO, I_KEEP, I_RND, I_FX, I_TRIG_S, I_TRIG_C
    } t_isel;

    typedef enum logic [2:0] {
        D_NONE, D_TRIG, D_FX, D_FY, D_PX, D_PY, D_PZ
    } t_dest;

    typedef struct packed {
        t_asel      a_sel;
        logic [2:0] b_idx;
        logic       b_store;
        logic       neg;
        logic       neg_right;
        t_isel      i_sel;
        t_dest      dest;
        logic [2:0] t_idx;
    } t_step;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    typedef struct packed {
        logic                       start;
        logic                       neg;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [TRIG_W-1:0]   b;
        logic signed [ACC_W-1:0]    init;
    } t_mac_req;

    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Each product step of the sequence: operands, sign, accumulator start and target.
    function automatic t_step step_decode(input t_op op);
        t_step s;
        s = '{a_sel: A_L1, b_idx: 3'd0, b_store: 1'b0, neg: 1'b0, neg_right: 1'b0,
              i_sel: I_ZERO, dest: D_NONE, t_idx: 3'd0};
        unique case (op)
            OP_F0S: s = '{A_D0, 3'd1, 1'b1, 1'b0, 1'b0, I_TRIG_S, D_TRIG, 3'd0};
            OP_F0C: s = '{A_D0, 3'd0, 1'b1, 1'b1, 1'b0, I_TRIG_C, D_TRIG, 3'd1};
            OP_F1S: s = '{A_D1, 3'd3, 1'b1, 1'b0, 1'b0, I_TRIG_S, D_TRIG, 3'd2};
            OP_F1C: s = '{A_D1, 3'd2, 1'b1, 1'b1, 1'b0, I_TRIG_C, D_TRIG, 3'd3};
            OP_F2S: s = '{A_D2, 3'd5, 1'b1, 1'b0, 1'b0, I_TRIG_S, D_TRIG, 3'd4};
            OP_F2C: s = '{A_D2, 3'd4, 1'b1, 1'b1, 1'b0, I_TRIG_C, D_TRIG, 3'd5};
            OP_FX1: s = '{A_L1, 3'd3, 1'b0, 1'b0, 1'b0, I_ZERO, D_NONE, 3'd0};
            OP_FX2: s = '{A_L2, 3'd5, 1'b0, 1'b1, 1'b0, I_KEEP, D_FX, 3'd0};
            OP_FY1: s = '{A_L1, 3'd2, 1'b0, 1'b1, 1'b0, I_ZERO, D_NONE, 3'd0};
            OP_FY2: s = '{A_L2, 3'd4, 1'b0, 1'b0, 1'b0, I_KEEP, D_FY, 3'd0};
            OP_PX1: s = '{A_L0S, 3'd1, 1'b0, 1'b1, 1'b1, I_RND, D_NONE, 3'd0};
            OP_PX2: s = '{A_FY, 3'd0, 1'b0, 1'b0, 1'b1, I_KEEP, D_PX, 3'd0};
            OP_PY1: s = '{A_L0S_LEFT, 3'd0, 1'b0, 1'b0, 1'b0, I_FX, D_PY, 3'd0};
            OP_PZ1: s = '{A_L0S_RIGHT, 3'd0, 1'b0, 1'b0, 1'b0, I_RND, D_NONE, 3'd0};
            OP_PZ2: s = '{A_FY, 3'd1, 1'b0, 1'b0, 1'b0, I_KEEP, D_PZ, 3'd0};
            default: s.dest = D_NONE;
        endcase
        return s;
    endfunction

endpackage

// File: design/lfk_serial_mac.sv
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on lfk_pkg for widths and the request and status structs.
module lfk_serial_mac import lfk_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_req                 i_req,
    output logic signed [ACC_W-1:0]  o_acc,
    output t_unit_status             o_status
);

    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  r_a, n_a;
    logic signed [TRIG_W-1:0] r_b, n_b;
    logic [MUL_CNT_W-1:0]     r_cnt, n_cnt;
    logic                     r_neg, n_neg;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic                     sub;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        sub    = r_neg ^ (r_cnt == MUL_CNT_W'(TRIG_W - 1));
        if (i_req.start) begin
            n_acc  = $signed(i_req.init);
            n_a    = ACC_W'($signed(i_req.a));
            n_b    = $signed(i_req.b);
            n_cnt  = '0;
            n_neg  = i_req.neg;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = sub ? (r_acc - r_a) : (r_acc + r_a);
            end
            n_a   = r_a <<< 1;
            n_b   = r_b >>> 1;
            n_cnt = r_cnt + MUL_CNT_W'(1);
            if (r_cnt == MUL_CNT_W'(TRIG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_acc    = r_acc;
    assign o_status = '{busy: r_busy, done: r_done};

endmodule

// File: design/lfk_cordic.sv
// Iterative CORDIC: range reduction by pi, then one rotation per cycle.
// Depends on lfk_pkg for the arctangent table, widths and state type.
module lfk_cordic import lfk_pkg::*; #(
    parameter int ITERATIONS  = CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [ANG_W:0]     i_angle,
    output logic signed [TRIG_W-1:0]  o_sin,
    output logic signed [TRIG_W-1:0]  o_cos,
    output t_unit_status              o_status
);

    localparam int RES_W = ANGLE_WIDTH + 6;
    localparam int SCALE = ANGLE_WIDTH - 12;
    localparam int SH    = 29 - ANGLE_WIDTH;
    localparam int ITERS = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
    localparam longint PI_F   = (PI_Q30 + (longint'(1) << (SH - 1))) >>> SH;
    localparam longint HALF_F = PI_F / 2;
    localparam logic signed [RES_W-1:0] PI_R    = RES_W'(PI_F);
    localparam logic signed [RES_W-1:0] HALF_R  = RES_W'(HALF_F);
    localparam logic signed [RES_W-1:0] NHALF_R = RES_W'(-HALF_F);
    localparam logic [XY_W-1:0] ATAN_RND = XY_W'(longint'(1) << (SH - 1));

    t_cor_state               r_state, n_state;
    logic signed [RES_W-1:0]  r_a, n_a;
    logic signed [XY_W-1:0]   r_x, n_x, r_y, n_y;
    logic [ATAN_IDX_W-1:0]    r_i, n_i;
    logic                     r_flip, n_flip;
    logic signed [TRIG_W-1:0] r_sin, n_sin, r_cos, n_cos;
    logic                     r_done, n_done;
    logic [XY_W-1:0]          atan_r;
    logic signed [RES_W-1:0]  step_ang;
    logic signed [XY_W-1:0]   dx, dy, xr, yr;
    logic                     last_iter;

    assign last_iter = (r_i == ATAN_IDX_W'(ITERS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            COR_IDLE:   if (i_start) n_state = COR_REDUCE;
            COR_REDUCE: if (!(r_a > HALF_R) && !(r_a < NHALF_R)) n_state = COR_ROTATE;
            COR_ROTATE: if (last_iter) n_state = COR_FINISH;
            COR_FINISH: n_state = COR_IDLE;
            default:    n_state = COR_IDLE;
        endcase
    end

    always_comb begin
        n_a    = r_a;
        n_x    = r_x;
        n_y    = r_y;
        n_i    = r_i;
        n_flip = r_flip;
        n_sin  = r_sin;
        n_cos  = r_cos;
        n_done = 1'b0;
        atan_r   = ({1'b0, atan_q30(r_i)} + ATAN_RND) >> SH;
        step_ang = $signed(atan_r[RES_W-1:0]);
        dx       = r_y >>> r_i;
        dy       = r_x >>> r_i;
        xr       = (r_x + 33'sd8192) >>> 14;
        yr       = (r_y + 33'sd8192) >>> 14;
        unique case (r_state)
            COR_IDLE: begin
                if (i_start) begin
                    n_a    = RES_W'(i_angle) <<< SCALE;
                    n_x    = CORDIC_GAIN;
                    n_y    = '0;
                    n_i    = '0;
                    n_flip = 1'b0;
                end
            end
            COR_REDUCE: begin
                if (r_a > HALF_R) begin
                    n_a    = r_a - PI_R;
                    n_flip = !r_flip;
                end else if (r_a < NHALF_R) begin
                    n_a    = r_a + PI_R;
                    n_flip = !r_flip;
                end
            end
            COR_ROTATE: begin
                if (!r_a[RES_W-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_a = r_a - step_ang;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_a = r_a + step_ang;
                end
                n_i = r_i + ATAN_IDX_W'(1);
            end
            COR_FINISH: begin
                if (r_flip) begin
                    xr = -xr;
                    yr = -yr;
                end
                n_sin  = yr[TRIG_W-1:0];
                n_cos  = xr[TRIG_W-1:0];
                n_done = 1'b1;
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_x    <= n_x;
        r_y    <= n_y;
        r_i    <= n_i;
        r_flip <= n_flip;
        r_sin  <= n_sin;
        r_cos  <= n_cos;
    end

    assign o_sin    = r_sin;
    assign o_cos    = r_cos;
    assign o_status = '{busy: (r_state != COR_IDLE), done: r_done};

endmodule

// File: design/leg_forward_kinematics.sv
// Top level of the three-joint leg forward kinematics block.
// Depends on lfk_pkg, lfk_cordic, lfk_serial_mac and the assertion macro header.
//
//  Channel   Direction  Signals                       Contents
//  config    in/out     psel penable pwrite paddr ..  leg side and three lengths
//  angles    in         s_axis_*                      operation and six joint angles
//  foot      out        m_axis_*                      foot x, y, z and clipped flag
//
// Exact mode runs three CORDIC passes, then nine products in the bit-serial
// multiplier. Fast mode runs fifteen products. The serial multiplier takes one
// multiplier bit per cycle.
// Reset is synchronous and active low; it clears the trig store and the lengths and sets the leg side to right.
// A finished result waits in the output register while the next transaction is
// taken; a result finished behind an untaken one waits until that is taken.
`include "leg_forward_kinematics_macros.svh"

module leg_forward_kinematics import lfk_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_WIDTH       = ANGLE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // shoulder, hip, knee, ref_shoulder, ref_hip, ref_knee angles, 16 bits each
    input  logic [95:0] s_axis_tdata,
    // operation
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // foot_x, foot_y, foot_z, 19 bits each, then 7 zero bits
    output logic [63:0] m_axis_tdata,
    // clipped
    output logic [0:0]  m_axis_tuser
);

    t_state                    r_state, n_state;
    logic                      r_leg_is_right;
    logic [LEN_W-1:0]          r_l0, r_l1, r_l2;
    logic                      r_mode;
    logic signed [ANG_W:0]     r_ang0, r_ang1, r_ang2;
    logic signed [ANG_W+1:0]   r_d0, r_d1, r_d2;
    logic [1:0]                r_cidx;
    t_op                       r_op;
    logic signed [TRIG_W-1:0]  r_store [6];
    logic signed [TRIG_W-1:0]  r_trig [6];
    logic signed [MUL_A_W-1:0] r_fx, r_fy;
    logic signed [POS_W-1:0]   r_px, r_py, r_pz;
    logic [2:0]                r_hit;
    logic                      r_m_valid;
    logic [63:0]               r_m_data;
    logic                      r_m_clip;

    logic                      cfg_write;
    logic                      in_accept;
    logic                      out_free;
    logic                      cor_start;
    logic signed [ANG_W:0]     cor_angle;
    logic signed [TRIG_W-1:0]  cor_sin, cor_cos;
    t_unit_status              cor_status;
    t_mac_req                  mac_req;
    logic signed [ACC_W-1:0]   mac_acc;
    t_unit_status              mac_status;
    t_step                     step;
    logic [MUL_A_W-1:0]        l0_shifted;
    logic signed [ANG_W-1:0]   in_a0, in_a1, in_a2, in_r0, in_r1, in_r2;
    logic [TRIG_W:0]           trig_sat;
    logic [POS_W:0]            pos_sat;

    localparam logic signed [ACC_W-1:0] RND32 = ACC_W'(longint'(1) << 31);

    function automatic logic [TRIG_W:0] sat_trig(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic                    ovf;
        v   = acc >>> 13;
        ovf = (v[ACC_W-1:TRIG_W-1] != {(ACC_W - TRIG_W + 1){v[ACC_W-1]}});
        if (ovf) begin
            return {1'b1, v[ACC_W-1], {(TRIG_W - 1){!v[ACC_W-1]}}};
        end
        return {1'b0, v[TRIG_W-1:0]};
    endfunction

    function automatic logic [POS_W:0] sat_pos(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic                    ovf;
        v   = acc >>> 32;
        ovf = (v[ACC_W-1:POS_W-1] != {(ACC_W - POS_W + 1){v[ACC_W-1]}});
        if (ovf) begin
            return {1'b1, v[ACC_W-1], {(POS_W - 1){!v[ACC_W-1]}}};
        end
        return {1'b0, v[POS_W-1:0]};
    endfunction

    assign in_a0 = $signed(s_axis_tdata[15:0]);
    assign in_a1 = $signed(s_axis_tdata[31:16]);
    assign in_a2 = $signed(s_axis_tdata[47:32]);
    assign in_r0 = $signed(s_axis_tdata[63:48]);
    assign in_r1 = $signed(s_axis_tdata[79:64]);
    assign in_r2 = $signed(s_axis_tdata[95:80]);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_LEG_IS_RIGHT: prdata = {31'd0, r_leg_is_right};
            REG_SHOULDER_LEN: prdata = {16'd0, r_l0};
            REG_UPPER_LEN:    prdata = {16'd0, r_l1};
            REG_LOWER_LEN:    prdata = {16'd0, r_l2};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser[0] == MODE_FAST) ? ST_MAC_START : ST_COR_START;
                end
            end
            ST_COR_START: n_state = ST_COR_WAIT;
            ST_COR_WAIT: begin
                if (cor_status.done) begin
                    n_state = (r_cidx == 2'd2) ? ST_MAC_START : ST_COR_START;
                end
            end
            ST_MAC_START: n_state = ST_MAC_WAIT;
            ST_MAC_WAIT: begin
                if (mac_status.done) begin
                    n_state = (r_op == OP_PZ2) ? ST_DONE : ST_MAC_START;
                end
            end
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        cor_start     = (r_state == ST_COR_START);
        mac_req.start = (r_state == ST_MAC_START);
    end

    always_comb begin
        case (r_cidx)
            2'd0:    cor_angle = r_ang0;
            2'd1:    cor_angle = r_ang1;
            default: cor_angle = r_ang2;
        endcase
    end

    assign step       = step_decode(r_op);
    assign l0_shifted = {4'd0, r_l0, 16'd0};

    always_comb begin
        case (step.a_sel)
            A_D0:        mac_req.a = MUL_A_W'(r_d0);
            A_D1:        mac_req.a = MUL_A_W'(r_d1);
            A_D2:        mac_req.a = MUL_A_W'(r_d2);
            A_L0S:       mac_req.a = l0_shifted;
            A_L1:        mac_req.a = {20'd0, r_l1};
            A_L2:        mac_req.a = {20'd0, r_l2};
            A_FY:        mac_req.a = r_fy;
            A_L0S_LEFT:  mac_req.a = r_leg_is_right ? '0 : l0_shifted;
            A_L0S_RIGHT: mac_req.a = r_leg_is_right ? l0_shifted : '0;
            default:     mac_req.a = '0;
        endcase
        mac_req.b   = step.b_store ? r_store[step.b_idx] : r_trig[step.b_idx];
        mac_req.neg = step.neg ^ (step.neg_right & r_leg_is_right);
        case (step.i_sel)
            I_ZERO:   mac_req.init = '0;
            I_KEEP:   mac_req.init = mac_acc;
            I_RND:    mac_req.init = RND32;
            I_FX:     mac_req.init = (ACC_W'(r_fx) <<< 16) + RND32;
            I_TRIG_S: mac_req.init = (ACC_W'(r_store[step.t_idx]) <<< 13) + ACC_W'(4096);
            I_TRIG_C: mac_req.init = (ACC_W'(r_store[step.t_idx]) <<< 13) + ACC_W'(4095);
            default:  mac_req.init = '0;
        endcase
    end

    assign trig_sat = sat_trig(mac_acc);
    assign pos_sat  = sat_pos(mac_acc);

    lfk_cordic #(
        .ITERATIONS  (CORDIC_ITERATIONS),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_angle  (cor_angle),
        .o_sin    (cor_sin),
        .o_cos    (cor_cos),
        .o_status (cor_status)
    );

    lfk_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mac_req),
        .o_acc    (mac_acc),
        .o_status (mac_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_leg_is_right <= 1'b1;
            r_l0           <= '0;
            r_l1           <= '0;
            r_l2           <= '0;
            r_m_valid      <= 1'b0;
            r_cidx         <= '0;
            r_op           <= OP_FX1;
            for (int k = 0; k < 6; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_LEG_IS_RIGHT: r_leg_is_right <= pwdata[0];
                    REG_SHOULDER_LEN: r_l0 <= pwdata[LEN_W-1:0];
                    REG_UPPER_LEN:    r_l1 <= pwdata[LEN_W-1:0];
                    REG_LOWER_LEN:    r_l2 <= pwdata[LEN_W-1:0];
                    default:          r_l0 <= r_l0;
                endcase
            end
            if (in_accept) begin
                r_cidx <= '0;
                r_op   <= (s_axis_tuser[0] == MODE_FAST) ? OP_F0S : OP_FX1;
            end
            if (r_state == ST_COR_WAIT && cor_status.done) begin
                r_store[{r_cidx, 1'b0}] <= cor_sin;
                r_store[{r_cidx, 1'b1}] <= cor_cos;
                r_cidx                  <= r_cidx + 2'd1;
            end
            if (r_state == ST_MAC_WAIT && mac_status.done && r_op != OP_PZ2) begin
                r_op <= t_op'(r_op + 4'd1);
            end
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= s_axis_tuser[0];
            r_ang0 <= (ANG_W + 1)'(in_a0);
            r_ang1 <= (ANG_W + 1)'(in_a1);
            r_ang2 <= (ANG_W + 1)'(in_a1) + (ANG_W + 1)'(in_a2);
            r_d0   <= (ANG_W + 2)'(in_a0) - (ANG_W + 2)'(in_r0);
            r_d1   <= (ANG_W + 2)'(in_a1) - (ANG_W + 2)'(in_r1);
            r_d2   <= (ANG_W + 2)'(in_a1) - (ANG_W + 2)'(in_r1)
                      + (ANG_W + 2)'(in_a2) - (ANG_W + 2)'(in_r2);
        end
        if (r_state == ST_COR_WAIT && cor_status.done) begin
            r_trig[{r_cidx, 1'b0}] <= cor_sin;
            r_trig[{r_cidx, 1'b1}] <= cor_cos;
        end
        if (r_state == ST_MAC_WAIT && mac_status.done) begin
            case (step.dest)
                D_TRIG: r_trig[step.t_idx] <= trig_sat[TRIG_W-1:0];
                D_FX:   r_fx <= mac_acc[MUL_A_W-1:0];
                D_FY:   r_fy <= mac_acc[MUL_A_W-1:0];
                D_PX: begin
                    r_px     <= pos_sat[POS_W-1:0];
                    r_hit[0] <= pos_sat[POS_W];
                end
                D_PY: begin
                    r_py     <= pos_sat[POS_W-1:0];
                    r_hit[1] <= pos_sat[POS_W];
                end
                D_PZ: begin
                    r_pz     <= pos_sat[POS_W-1:0];
                    r_hit[2] <= pos_sat[POS_W];
                end
                default: r_fx <= r_fx;
            endcase
        end
        if (r_state == ST_DONE && out_free) begin
            r_m_data <= {7'd0, r_pz, r_py, r_px};
            r_m_clip <= |r_hit;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_clip;

    // The mode is held for the whole transaction.
    `LFK_ASSERT_IMPLY(a_mode_held, i_clk, i_rst_n, r_state == ST_MAC_WAIT && !in_accept, $stable(r_mode) || $past(in_accept), "mode changed during a transaction")
    `LFK_ASSERT_IMPLY(a_mac_start_idle, i_clk, i_rst_n, mac_req.start, !mac_status.busy, "multiplier started while busy")
    `LFK_ASSERT_IMPLY(a_units_idle, i_clk, i_rst_n, s_axis_tready, !mac_status.busy && !cor_status.busy, "input ready while a unit is busy")
    `LFK_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_accept, !s_axis_tready, "second transaction taken back to back")
    `LFK_ASSERT_IMPLY(a_load_from_done, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(r_state == ST_DONE), "result loaded outside the done state")

endmodule
